// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset
`define GFV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check a property on every edge, reset included
`define GFV_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ----- design/gfv_pkg.sv -----
// ----------------------------------------------------------------------------
// gfv_pkg
// Widths, register map and constants of the gravity force vector unit.
// ----------------------------------------------------------------------------
package gfv_pkg;

  // Field widths
  localparam int POS_W   = 32;
  localparam int MASS_W  = 32;
  localparam int G_W     = 32;
  localparam int FORCE_W = 32;
  localparam int DIFF_W  = 33;
  localparam int SQ_W    = 66;
  localparam int LEN_W   = 33;
  localparam int DSQ_W   = 48;
  localparam int NUM_W   = 96;

  // Stream widths
  localparam int IN_DATA_W  = 6 * POS_W;
  localparam int OUT_DATA_W = 2 * FORCE_W;

  // Configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;

  localparam logic [1:0] REG_GRAV    = 2'd0;
  localparam logic [1:0] REG_MIN_DSQ = 2'd1;
  localparam logic [1:0] REG_MAX_DSQ = 2'd2;

  localparam logic [G_W-1:0]   GRAV_RESET    = 32'h0001_0000;
  localparam logic [DSQ_W-1:0] MIN_DSQ_RESET = 48'h0000_0001_0000;
  localparam logic [DSQ_W-1:0] MAX_DSQ_RESET = 48'hFFFF_FFFF_FFFF;

  // Saturation limits
  localparam logic [FORCE_W-1:0] FORCE_MAX = 32'h7FFF_FFFF;
  localparam logic [FORCE_W-1:0] FORCE_MIN = 32'h8000_0000;

endpackage

// ----- design/gfv_isqrt.sv -----
// ----------------------------------------------------------------------------
// gfv_isqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module gfv_isqrt #(
  parameter int IN_W = 66,
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   in_rad,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_valid,
  output logic [IN_W/2-1:0] out_root,
  output logic [SB_W-1:0]   out_sb
);

  localparam int R_W   = IN_W / 2;
  localparam int REM_W = R_W + 2;
  localparam int T_W   = R_W + 4;

  logic [IN_W-1:0]  rad_r   [R_W];
  logic [R_W-1:0]   root_r  [R_W];
  logic [REM_W-1:0] rem_r   [R_W];
  logic [SB_W-1:0]  sb_r    [R_W];
  logic [R_W-1:0]   v_r;

  logic [IN_W-1:0]  rad_nxt [R_W];
  logic [R_W-1:0]   root_nxt[R_W];
  logic [REM_W-1:0] rem_nxt [R_W];

  logic [IN_W-1:0]  s_rad;
  logic [R_W-1:0]   s_root;
  logic [REM_W-1:0] s_rem;
  logic [T_W-1:0]   t;
  logic [T_W-1:0]   trial;
  logic             ge;

  // One digit per stage: bring down two radicand bits, try root*4+1
  always_comb begin
    s_rad  = '0;
    s_root = '0;
    s_rem  = '0;
    t      = '0;
    trial  = '0;
    ge     = 1'b0;
    for (int k = 0; k < R_W; k++) begin
      if (k == 0) begin
        s_rad  = in_rad;
        s_root = '0;
        s_rem  = '0;
      end else begin
        s_rad  = rad_r[k-1];
        s_root = root_r[k-1];
        s_rem  = rem_r[k-1];
      end
      t           = {s_rem, s_rad[IN_W-1 -: 2]};
      trial       = {2'b00, s_root, 2'b01};
      ge          = (t >= trial);
      rem_nxt[k]  = ge ? REM_W'(t - trial) : t[REM_W-1:0];
      root_nxt[k] = {s_root[R_W-2:0], ge};
      rad_nxt[k]  = {s_rad[IN_W-3:0], 2'b00};
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[R_W-2:0], in_valid};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= in_sb;
      for (int k = 1; k < R_W; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
      for (int k = 0; k < R_W; k++) begin
        rad_r[k]  <= rad_nxt[k];
        root_r[k] <= root_nxt[k];
        rem_r[k]  <= rem_nxt[k];
      end
    end
  end

  assign out_valid = v_r[R_W-1];
  assign out_root  = root_r[R_W-1];
  assign out_sb    = sb_r[R_W-1];

endmodule

// ----- design/gfv_udiv.sv -----
// ----------------------------------------------------------------------------
// gfv_udiv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module gfv_udiv #(
  parameter int Q_W   = 32,
  parameter int DEN_W = 33,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DEN_W-1:0] in_rem,
  input  logic [Q_W-1:0]   in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [SB_W-1:0]  in_sb,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_quo,
  output logic [SB_W-1:0]  out_sb
);

  logic [DEN_W-1:0] rem_r   [Q_W];
  logic [Q_W-1:0]   num_r   [Q_W];
  logic [DEN_W-1:0] den_r   [Q_W];
  logic [SB_W-1:0]  sb_r    [Q_W];
  logic [Q_W-1:0]   v_r;

  logic [DEN_W-1:0] rem_nxt [Q_W];
  logic [Q_W-1:0]   num_nxt [Q_W];

  logic [DEN_W-1:0] s_rem;
  logic [DEN_W-1:0] s_den;
  logic [Q_W-1:0]   s_num;
  logic [DEN_W:0]   t;
  logic             ge;

  // Shift in the next numerator bit, subtract the divisor where it fits
  always_comb begin
    s_rem = '0;
    s_den = '0;
    s_num = '0;
    t     = '0;
    ge    = 1'b0;
    for (int k = 0; k < Q_W; k++) begin
      if (k == 0) begin
        s_rem = in_rem;
        s_den = in_den;
        s_num = in_num;
      end else begin
        s_rem = rem_r[k-1];
        s_den = den_r[k-1];
        s_num = num_r[k-1];
      end
      t          = {s_rem, s_num[Q_W-1]};
      ge         = (t >= {1'b0, s_den});
      rem_nxt[k] = ge ? DEN_W'(t - {1'b0, s_den}) : t[DEN_W-1:0];
      num_nxt[k] = {s_num[Q_W-2:0], ge};
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Q_W-2:0], in_valid};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= in_den;
      sb_r[0]  <= in_sb;
      for (int k = 1; k < Q_W; k++) begin
        den_r[k] <= den_r[k-1];
        sb_r[k]  <= sb_r[k-1];
      end
      for (int k = 0; k < Q_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        num_r[k] <= num_nxt[k];
      end
    end
  end

  assign out_valid = v_r[Q_W-1];
  assign out_quo   = num_r[Q_W-1];
  assign out_sb    = sb_r[Q_W-1];

endmodule

// ----- design/gravity_force_vector_unit.sv -----
// ----------------------------------------------------------------------------
// gravity_force_vector_unit
// Planar Newtonian gravity between two point bodies, fixed point, pipelined.
// ----------------------------------------------------------------------------
// The unit takes one body pair per cycle while the pipeline can move (output
// register empty or out_tready high) and returns one force vector per pair,
// in order. A pair passes five front stages (difference, squares and mass
// product), a 33-stage square root, a (96 - FRAC_BITS)-stage divider for the
// magnitude, three stages of partial products and saturation checks, a
// 32-stage divider per component and the output register. The whole pipeline
// holds while a result waits on out_tready, so nothing is lost or repeated.
// Registers are written over the APB port at byte addresses 0, 8 and 16
// (grav_constant, min_dist_sq, max_dist_sq) and must only change while idle.
`include "assert_macros.svh"

module gravity_force_vector_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // pos_a_x, pos_a_y, pos_b_x, pos_b_y, mass_a, mass_b (lowest bit up)
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [gfv_pkg::IN_DATA_W-1:0]  in_tdata,
  // force_x, force_y (lowest bit up)
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [gfv_pkg::OUT_DATA_W-1:0] out_tdata,
  // saturated
  output logic [0:0]                     out_tuser,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [gfv_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [gfv_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [gfv_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                           cfg_pready
);

  localparam int POS_W   = gfv_pkg::POS_W;
  localparam int MASS_W  = gfv_pkg::MASS_W;
  localparam int G_W     = gfv_pkg::G_W;
  localparam int FORCE_W = gfv_pkg::FORCE_W;
  localparam int DIFF_W  = gfv_pkg::DIFF_W;
  localparam int SQ_W    = gfv_pkg::SQ_W;
  localparam int LEN_W   = gfv_pkg::LEN_W;
  localparam int DSQ_W   = gfv_pkg::DSQ_W;
  localparam int NUM_W   = gfv_pkg::NUM_W;

  localparam int MAG_W   = NUM_W - FRAC_BITS;
  localparam int DSH_W   = SQ_W - FRAC_BITS;
  localparam int CMP_W   = (DSH_W > DSQ_W) ? DSH_W : DSQ_W;
  localparam int NCH     = (MAG_W + 31) / 32;
  localparam int PP_W    = 32 + DIFF_W;
  localparam int SUM_W   = NCH * 32 + DIFF_W;
  localparam int THR_W   = LEN_W + 32;
  localparam int SQ_SB_W = DSQ_W + MAG_W + 2 * DIFF_W + 3;
  localparam int MD_SB_W = LEN_W + 2 * DIFF_W + 3;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [G_W-1:0]   grav_r;
  logic [DSQ_W-1:0] min_dsq_r;
  logic [DSQ_W-1:0] max_dsq_r;
  logic [1:0]       cfg_idx;

  assign cfg_idx    = cfg_paddr[4:3];
  assign cfg_pready = 1'b1;

  // Write on the access phase; unmapped addresses drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r    <= gfv_pkg::GRAV_RESET;
      min_dsq_r <= gfv_pkg::MIN_DSQ_RESET;
      max_dsq_r <= gfv_pkg::MAX_DSQ_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_idx)
        gfv_pkg::REG_GRAV:    grav_r    <= cfg_pwdata[G_W-1:0];
        gfv_pkg::REG_MIN_DSQ: min_dsq_r <= cfg_pwdata[DSQ_W-1:0];
        gfv_pkg::REG_MAX_DSQ: max_dsq_r <= cfg_pwdata[DSQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (cfg_idx)
      gfv_pkg::REG_GRAV:    cfg_prdata = 64'(grav_r);
      gfv_pkg::REG_MIN_DSQ: cfg_prdata = 64'(min_dsq_r);
      gfv_pkg::REG_MAX_DSQ: cfg_prdata = 64'(max_dsq_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: everything moves when the output can move
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_r;

  assign en        = out_tready || !out_valid_r;
  assign in_tready = en;

  logic [4:0] fv_r;
  logic [2:0] bv_r;

  // Input fields
  logic [POS_W-1:0]  pos_a_x, pos_a_y, pos_b_x, pos_b_y;
  logic [MASS_W-1:0] mass_a, mass_b;

  assign pos_a_x = in_tdata[0*POS_W +: POS_W];
  assign pos_a_y = in_tdata[1*POS_W +: POS_W];
  assign pos_b_x = in_tdata[2*POS_W +: POS_W];
  assign pos_b_y = in_tdata[3*POS_W +: POS_W];
  assign mass_a  = in_tdata[4*POS_W +: MASS_W];
  assign mass_b  = in_tdata[4*POS_W+MASS_W +: MASS_W];

  // Stage 1: differences
  logic [DIFF_W-1:0] s1_dx_r, s1_dy_r;
  logic [MASS_W-1:0] s1_ma_r, s1_mb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r <= {pos_b_x[POS_W-1], pos_b_x} - {pos_a_x[POS_W-1], pos_a_x};
      s1_dy_r <= {pos_b_y[POS_W-1], pos_b_y} - {pos_a_y[POS_W-1], pos_a_y};
      s1_ma_r <= mass_a;
      s1_mb_r <= mass_b;
    end
  end

  // Stage 2: magnitudes, signs, G * mass_a
  logic [DIFF_W-1:0]       s2_ax_r, s2_ay_r;
  logic                    s2_sx_r, s2_sy_r, s2_zero_r;
  logic [G_W+MASS_W-1:0]   s2_gm_r;
  logic [MASS_W-1:0]       s2_mb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ax_r   <= s1_dx_r[DIFF_W-1] ? DIFF_W'(~s1_dx_r + 1'b1) : s1_dx_r;
      s2_ay_r   <= s1_dy_r[DIFF_W-1] ? DIFF_W'(~s1_dy_r + 1'b1) : s1_dy_r;
      s2_sx_r   <= s1_dx_r[DIFF_W-1];
      s2_sy_r   <= s1_dy_r[DIFF_W-1];
      s2_zero_r <= (s1_dx_r == '0) && (s1_dy_r == '0);
      s2_gm_r   <= (G_W+MASS_W)'(grav_r) * (G_W+MASS_W)'(s1_ma_r);
      s2_mb_r   <= s1_mb_r;
    end
  end

  // Stage 3: squares and the two halves of G * mass_a * mass_b
  logic [SQ_W-1:0]   s3_sqx_r, s3_sqy_r;
  logic [63:0]       s3_pnl_r, s3_pnh_r;
  logic [DIFF_W-1:0] s3_ax_r, s3_ay_r;
  logic              s3_sx_r, s3_sy_r, s3_zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sqx_r  <= SQ_W'(s2_ax_r) * SQ_W'(s2_ax_r);
      s3_sqy_r  <= SQ_W'(s2_ay_r) * SQ_W'(s2_ay_r);
      s3_pnl_r  <= 64'(s2_gm_r[31:0]) * 64'(s2_mb_r);
      s3_pnh_r  <= 64'(s2_gm_r[63:32]) * 64'(s2_mb_r);
      s3_ax_r   <= s2_ax_r;
      s3_ay_r   <= s2_ay_r;
      s3_sx_r   <= s2_sx_r;
      s3_sy_r   <= s2_sy_r;
      s3_zero_r <= s2_zero_r;
    end
  end

  // Stage 4: squared length and the scaled numerator
  logic [NUM_W-1:0]  s4_num;
  logic [SQ_W-1:0]   s4_ssq_r;
  logic [MAG_W-1:0]  s4_num_r;
  logic [DIFF_W-1:0] s4_ax_r, s4_ay_r;
  logic              s4_sx_r, s4_sy_r, s4_zero_r;

  assign s4_num = {s3_pnh_r, 32'd0} + {32'd0, s3_pnl_r};

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ssq_r  <= s3_sqx_r + s3_sqy_r;
      s4_num_r  <= s4_num[NUM_W-1 -: MAG_W];
      s4_ax_r   <= s3_ax_r;
      s4_ay_r   <= s3_ay_r;
      s4_sx_r   <= s3_sx_r;
      s4_sy_r   <= s3_sy_r;
      s4_zero_r <= s3_zero_r;
    end
  end

  // Stage 5: clamp the squared length, lower bound first
  logic [CMP_W-1:0]  dsq_raw, dsq_lo, dsq_hi;
  logic [DSQ_W-1:0]  dsq_clamp;
  logic [DSQ_W-1:0]  s5_dsq_r;
  logic [SQ_W-1:0]   s5_ssq_r;
  logic [MAG_W-1:0]  s5_num_r;
  logic [DIFF_W-1:0] s5_ax_r, s5_ay_r;
  logic              s5_sx_r, s5_sy_r, s5_zero_r;

  always_comb begin
    dsq_raw   = CMP_W'(s4_ssq_r[SQ_W-1:FRAC_BITS]);
    dsq_lo    = (dsq_raw < CMP_W'(min_dsq_r)) ? CMP_W'(min_dsq_r) : dsq_raw;
    dsq_hi    = (dsq_lo > CMP_W'(max_dsq_r)) ? CMP_W'(max_dsq_r) : dsq_lo;
    dsq_clamp = (dsq_hi == '0) ? DSQ_W'(1) : dsq_hi[DSQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_dsq_r  <= dsq_clamp;
      s5_ssq_r  <= s4_ssq_r;
      s5_num_r  <= s4_num_r;
      s5_ax_r   <= s4_ax_r;
      s5_ay_r   <= s4_ay_r;
      s5_sx_r   <= s4_sx_r;
      s5_sy_r   <= s4_sy_r;
      s5_zero_r <= s4_zero_r;
    end
  end

  // Front valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (en) begin
      fv_r <= {fv_r[3:0], in_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // Length: square root of the exact squared length
  // --------------------------------------------------------------------------
  logic [SQ_SB_W-1:0] sq_sb_out;
  logic               sq_v;
  logic [LEN_W-1:0]   sq_len;
  logic [DSQ_W-1:0]   sq_dsq;
  logic [MAG_W-1:0]   sq_num;
  logic [DIFF_W-1:0]  sq_ax, sq_ay;
  logic               sq_sx, sq_sy, sq_zero;

  gfv_isqrt #(
    .IN_W (SQ_W),
    .SB_W (SQ_SB_W)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fv_r[4]),
    .in_rad    (s5_ssq_r),
    .in_sb     ({s5_dsq_r, s5_num_r, s5_ax_r, s5_ay_r, s5_sx_r, s5_sy_r, s5_zero_r}),
    .out_valid (sq_v),
    .out_root  (sq_len),
    .out_sb    (sq_sb_out)
  );

  assign {sq_dsq, sq_num, sq_ax, sq_ay, sq_sx, sq_sy, sq_zero} = sq_sb_out;

  // --------------------------------------------------------------------------
  // Magnitude: scaled numerator over the clamped squared length
  // --------------------------------------------------------------------------
  logic               md_v;
  logic [MAG_W-1:0]   md_mag;
  logic [MD_SB_W-1:0] md_sb_out;
  logic [LEN_W-1:0]   md_len;
  logic [DIFF_W-1:0]  md_ax, md_ay;
  logic               md_sx, md_sy, md_zero;

  gfv_udiv #(
    .Q_W   (MAG_W),
    .DEN_W (DSQ_W),
    .SB_W  (MD_SB_W)
  ) u_mag_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_v),
    .in_rem    ('0),
    .in_num    (sq_num),
    .in_den    (sq_dsq),
    .in_sb     ({sq_len, sq_ax, sq_ay, sq_sx, sq_sy, sq_zero}),
    .out_valid (md_v),
    .out_quo   (md_mag),
    .out_sb    (md_sb_out)
  );

  assign {md_len, md_ax, md_ay, md_sx, md_sy, md_zero} = md_sb_out;

  // --------------------------------------------------------------------------
  // Components: magnitude times |d|, checked against the limit times length
  // --------------------------------------------------------------------------
  logic [NCH*32-1:0] mag_pad;
  assign mag_pad = (NCH*32)'(md_mag);

  // Stage 6: partial products, 32 magnitude bits each
  logic [PP_W-1:0]  s6_ppx_r [NCH];
  logic [PP_W-1:0]  s6_ppy_r [NCH];
  logic [LEN_W-1:0] s6_len_r;
  logic             s6_sx_r, s6_sy_r, s6_zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NCH; k++) begin
        s6_ppx_r[k] <= PP_W'(mag_pad[32*k +: 32]) * PP_W'(md_ax);
        s6_ppy_r[k] <= PP_W'(mag_pad[32*k +: 32]) * PP_W'(md_ay);
      end
      s6_len_r  <= md_len;
      s6_sx_r   <= md_sx;
      s6_sy_r   <= md_sy;
      s6_zero_r <= md_zero;
    end
  end

  // Stage 7: full products and the clip thresholds (limit + 1) * length
  logic [SUM_W-1:0] px_sum, py_sum;
  logic [SUM_W-1:0] s7_px_r, s7_py_r;
  logic [THR_W-1:0] s7_thrx_r, s7_thry_r;
  logic [LEN_W-1:0] s7_len_r;
  logic             s7_sx_r, s7_sy_r, s7_zero_r;

  always_comb begin
    px_sum = '0;
    py_sum = '0;
    for (int k = 0; k < NCH; k++) begin
      px_sum = px_sum + (SUM_W'(s6_ppx_r[k]) << (32 * k));
      py_sum = py_sum + (SUM_W'(s6_ppy_r[k]) << (32 * k));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_px_r   <= px_sum;
      s7_py_r   <= py_sum;
      s7_thrx_r <= THR_W'({s6_len_r, 31'd0}) + (s6_sx_r ? THR_W'(s6_len_r) : '0);
      s7_thry_r <= THR_W'({s6_len_r, 31'd0}) + (s6_sy_r ? THR_W'(s6_len_r) : '0);
      s7_len_r  <= s6_len_r;
      s7_sx_r   <= s6_sx_r;
      s7_sy_r   <= s6_sy_r;
      s7_zero_r <= s6_zero_r;
    end
  end

  // Stage 8: clip flags; split each product into remainder and low word
  logic             s8_satx_r, s8_saty_r;
  logic [LEN_W-1:0] s8_rx_r, s8_ry_r;
  logic [31:0]      s8_nx_r, s8_ny_r;
  logic [LEN_W-1:0] s8_len_r;
  logic             s8_sx_r, s8_sy_r, s8_zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_satx_r <= (s7_px_r >= SUM_W'(s7_thrx_r));
      s8_saty_r <= (s7_py_r >= SUM_W'(s7_thry_r));
      s8_rx_r   <= s7_px_r[32 +: LEN_W];
      s8_ry_r   <= s7_py_r[32 +: LEN_W];
      s8_nx_r   <= s7_px_r[31:0];
      s8_ny_r   <= s7_py_r[31:0];
      s8_len_r  <= s7_len_r;
      s8_sx_r   <= s7_sx_r;
      s8_sy_r   <= s7_sy_r;
      s8_zero_r <= s7_zero_r;
    end
  end

  // Back valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else if (en) begin
      bv_r <= {bv_r[1:0], md_v};
    end
  end

  // Quotients by the length, 32 bits each
  logic        cx_v, cy_v;
  logic [31:0] cx_q, cy_q;
  logic [2:0]  cx_sb;
  logic [1:0]  cy_sb;

  gfv_udiv #(
    .Q_W   (32),
    .DEN_W (LEN_W),
    .SB_W  (3)
  ) u_x_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (bv_r[2]),
    .in_rem    (s8_rx_r),
    .in_num    (s8_nx_r),
    .in_den    (s8_len_r),
    .in_sb     ({s8_zero_r, s8_satx_r, s8_sx_r}),
    .out_valid (cx_v),
    .out_quo   (cx_q),
    .out_sb    (cx_sb)
  );

  gfv_udiv #(
    .Q_W   (32),
    .DEN_W (LEN_W),
    .SB_W  (2)
  ) u_y_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (bv_r[2]),
    .in_rem    (s8_ry_r),
    .in_num    (s8_ny_r),
    .in_den    (s8_len_r),
    .in_sb     ({s8_saty_r, s8_sy_r}),
    .out_valid (cy_v),
    .out_quo   (cy_q),
    .out_sb    (cy_sb)
  );

  // --------------------------------------------------------------------------
  // Output register: sign, clip, zero-difference override
  // --------------------------------------------------------------------------
  logic [FORCE_W-1:0] fx_nxt, fy_nxt;
  logic               sat_nxt;
  logic [FORCE_W-1:0] fx_r, fy_r;
  logic               sat_r;

  always_comb begin
    if (cx_sb[2]) begin
      fx_nxt  = '0;
      fy_nxt  = '0;
      sat_nxt = 1'b0;
    end else begin
      if (cx_sb[1]) begin
        fx_nxt = cx_sb[0] ? gfv_pkg::FORCE_MIN : gfv_pkg::FORCE_MAX;
      end else begin
        fx_nxt = cx_sb[0] ? FORCE_W'(~cx_q + 1'b1) : cx_q;
      end
      if (cy_sb[1]) begin
        fy_nxt = cy_sb[0] ? gfv_pkg::FORCE_MIN : gfv_pkg::FORCE_MAX;
      end else begin
        fy_nxt = cy_sb[0] ? FORCE_W'(~cy_q + 1'b1) : cy_q;
      end
      sat_nxt = cx_sb[1] || cy_sb[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cx_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx_r  <= fx_nxt;
      fy_r  <= fy_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {fy_r, fx_r};
  assign out_tuser  = sat_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic out_at_limit;

  // Flag a component sitting at either limit
  assign out_at_limit = (fx_r == gfv_pkg::FORCE_MAX) || (fx_r == gfv_pkg::FORCE_MIN) ||
                        (fy_r == gfv_pkg::FORCE_MAX) || (fy_r == gfv_pkg::FORCE_MIN);

  // Reset empties the output
  `GFV_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid_r)
  // A clip flag always comes with a component at a limit
  `GFV_ASSERT(a_sat_at_limit, out_valid_r && sat_r |-> out_at_limit)
  // A waiting result freezes the pipeline
  `GFV_ASSERT(a_stall_holds, out_valid_r && !out_tready |=> $stable({fv_r, bv_r, sq_v, md_v}))
  // Both component dividers run in lockstep
  `GFV_ASSERT(a_div_lockstep, cx_v == cy_v)

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gravity force vector unit: body pairs go in as
// stream items, each force result is compared field by field with an in-bench
// fixed-point prediction, across several register settings and with random
// idling and back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [gfv_pkg::MASS_W-1:0] mass_b;
    logic [gfv_pkg::MASS_W-1:0] mass_a;
    logic [gfv_pkg::POS_W-1:0]  pos_b_y;
    logic [gfv_pkg::POS_W-1:0]  pos_b_x;
    logic [gfv_pkg::POS_W-1:0]  pos_a_y;
    logic [gfv_pkg::POS_W-1:0]  pos_a_x;
  } body_pair_t;

  typedef struct packed {
    logic                        saturated;
    logic [gfv_pkg::FORCE_W-1:0] force_y;
    logic [gfv_pkg::FORCE_W-1:0] force_x;
  } force_vec_t;

  localparam int FRAC = 16;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // pos_a_x, pos_a_y, pos_b_x, pos_b_y, mass_a, mass_b (lowest bit up)
  logic [gfv_pkg::IN_DATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  // force_x, force_y (lowest bit up)
  logic [gfv_pkg::OUT_DATA_W-1:0] out_tdata;
  // saturated
  logic [0:0] out_tuser;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [gfv_pkg::CFG_AW-1:0] cfg_paddr;
  logic [gfv_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [gfv_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  // Register copies used by the prediction
  logic [gfv_pkg::G_W-1:0]   grav_k;
  logic [gfv_pkg::DSQ_W-1:0] dsq_lo;
  logic [gfv_pkg::DSQ_W-1:0] dsq_hi;

  force_vec_t pending_forces[$];
  int  errors;
  bit  quiet;
  bit  hold_req;

  gravity_force_vector_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Square root, floor, of a 66-bit value
  function automatic logic [gfv_pkg::LEN_W-1:0] isqrt(logic [gfv_pkg::SQ_W-1:0] v);
    logic [gfv_pkg::LEN_W-1:0] r;
    logic [gfv_pkg::LEN_W-1:0] c;
    r = '0;
    for (int b = gfv_pkg::LEN_W - 1; b >= 0; b--) begin
      c = r | (33'd1 << b);
      if (68'(c) * 68'(c) <= 68'(v)) r = c;
    end
    return r;
  endfunction

  // One component: mag * |c| / len with the sign of c, clipped to 32 bits
  function automatic logic [gfv_pkg::FORCE_W:0] scale_component(logic [95:0] mag,
      logic signed [gfv_pkg::DIFF_W-1:0] c, logic [gfv_pkg::LEN_W-1:0] len);
    logic [gfv_pkg::DIFF_W-1:0] a;
    logic [127:0] q;
    logic [127:0] limit;
    logic clip;
    a = c[gfv_pkg::DIFF_W-1] ? -c : c;
    q = (128'(mag) * 128'(a)) / 128'(len);
    limit = c[gfv_pkg::DIFF_W-1] ? 128'h8000_0000 : 128'h7FFF_FFFF;
    clip = q > limit;
    if (clip) q = limit;
    return {clip, c[gfv_pkg::DIFF_W-1] ? -q[31:0] : q[31:0]};
  endfunction

  function automatic force_vec_t predict_force(body_pair_t p);
    logic signed [gfv_pkg::DIFF_W-1:0] dx;
    logic signed [gfv_pkg::DIFF_W-1:0] dy;
    logic [gfv_pkg::DIFF_W-1:0] ux;
    logic [gfv_pkg::DIFF_W-1:0] uy;
    logic [gfv_pkg::SQ_W-1:0] s;
    logic [63:0] dsq;
    logic [gfv_pkg::LEN_W-1:0] len;
    logic [95:0] mag;
    logic [gfv_pkg::FORCE_W:0] cx;
    logic [gfv_pkg::FORCE_W:0] cy;
    force_vec_t f;
    dx = $signed({p.pos_b_x[31], p.pos_b_x}) - $signed({p.pos_a_x[31], p.pos_a_x});
    dy = $signed({p.pos_b_y[31], p.pos_b_y}) - $signed({p.pos_a_y[31], p.pos_a_y});
    if (dx == 0 && dy == 0) return '0;
    ux = dx[gfv_pkg::DIFF_W-1] ? -dx : dx;
    uy = dy[gfv_pkg::DIFF_W-1] ? -dy : dy;
    s = 66'(ux) * 66'(ux) + 66'(uy) * 66'(uy);
    dsq = 64'(s >> FRAC);
    // lower clamp first, so the upper one wins when they cross
    if (dsq < 64'(dsq_lo)) dsq = 64'(dsq_lo);
    if (dsq > 64'(dsq_hi)) dsq = 64'(dsq_hi);
    if (dsq == 0) dsq = 64'd1;
    len = isqrt(s);
    mag = ((96'(grav_k) * 96'(p.mass_a) * 96'(p.mass_b)) >> FRAC) / 96'(dsq);
    cx = scale_component(mag, dx, len);
    cy = scale_component(mag, dy, len);
    f.force_x = cx[31:0];
    f.force_y = cy[31:0];
    f.saturated = cx[32] | cy[32];
    return f;
  endfunction

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Check every accepted result against the oldest prediction
  always @(negedge clk) begin
    force_vec_t want;
    force_vec_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tdata[63:32], out_tdata[31:0]};
      if (pending_forces.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_forces.pop_front();
        if (got.force_x !== want.force_x) begin
          $display("%0t: force_x expected %h actual %h", $time, want.force_x,
                   got.force_x);
          errors++;
        end
        if (got.force_y !== want.force_y) begin
          $display("%0t: force_y expected %h actual %h", $time, want.force_y,
                   got.force_y);
          errors++;
        end
        if (got.saturated !== want.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                   got.saturated);
          errors++;
        end
      end
    end
  end

  // Offer one item, with an optional idle burst first
  task automatic send_pair(body_pair_t p);
    bit rdy;
    force_vec_t f;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    f = predict_force(p);
    in_tvalid <= 1'b1;
    in_tdata <= p;
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    pending_forces.push_back(f);
  endtask

  // Hold off until every result is back and the pipeline is empty
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (170) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      gfv_pkg::REG_GRAV:    grav_k = val[gfv_pkg::G_W-1:0];
      gfv_pkg::REG_MIN_DSQ: dsq_lo = val[gfv_pkg::DSQ_W-1:0];
      gfv_pkg::REG_MAX_DSQ: dsq_hi = val[gfv_pkg::DSQ_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] g, logic [47:0] lo, logic [47:0] hi);
    drain();
    cfg_write(gfv_pkg::REG_GRAV, 64'(g));
    cfg_write(gfv_pkg::REG_MIN_DSQ, 64'(lo));
    cfg_write(gfv_pkg::REG_MAX_DSQ, 64'(hi));
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_mass();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom;
      4, 5: return $urandom_range(0, 32'h0004_0000);
      default: return $urandom_range(0, 32'h0100_0000);
    endcase
  endfunction

  // Mostly nearby bodies, with coincident, axis-aligned and extreme pairs
  function automatic body_pair_t random_pair();
    body_pair_t p;
    int kind;
    kind = $urandom_range(0, 9);
    p.pos_a_x = $urandom;
    p.pos_a_y = $urandom;
    p.mass_a = pick_mass();
    p.mass_b = pick_mass();
    case (kind)
      0: begin
        p.pos_b_x = p.pos_a_x;
        p.pos_b_y = p.pos_a_y;
      end
      1, 2, 3, 4, 5: begin
        p.pos_b_x = p.pos_a_x + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        p.pos_b_y = p.pos_a_y + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      end
      6, 7: begin
        p.pos_b_x = $urandom;
        p.pos_b_y = $urandom;
      end
      8: begin
        p.pos_a_x = pick_coord();
        p.pos_a_y = pick_coord();
        p.pos_b_x = pick_coord();
        p.pos_b_y = pick_coord();
      end
      default: begin
        p.pos_b_x = $urandom_range(0, 1) ? p.pos_a_x
                                         : p.pos_a_x + $urandom_range(1, 65536 * 8);
        p.pos_b_y = p.pos_b_x == p.pos_a_x ? p.pos_a_y - $urandom_range(1, 65536 * 8)
                                           : p.pos_a_y;
      end
    endcase
    return p;
  endfunction

  task automatic send_random(int n);
    repeat (n) send_pair(random_pair());
  endtask

  // Extremes, coincident bodies and zero/full masses under reset registers
  task automatic test_directed();
    logic [31:0] one;
    one = 32'h0001_0000;
    send_pair('{one, one, 32'h0, one, 32'h0, 32'h0});
    send_pair('{one, one, 32'h5, 32'h5, 32'h5, 32'h5});
    send_pair('{32'h0, one, 32'h0, one, 32'h0, 32'h0});
    send_pair('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000});
    send_pair('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_pair('{one, one, 32'h0, 32'h0003_0000, 32'h0, 32'h0});
    send_pair('{one, one, 32'hFFFC_0000, 32'h0, 32'h0, 32'h0});
    send_pair('{one, one, 32'h0, 32'h1, 32'h0, 32'h0});
    send_pair('{32'h0010_0000, 32'h0010_0000, 32'h0020_0000, 32'h0020_0000, 32'h0, 32'h0});
    send_pair('{32'h0000_0100, 32'h0000_0100, 32'hFFF0_0000, 32'h7FFF_0000,
                32'h000F_0000, 32'h8000_0000});
    send_pair('{32'h0000_4000, 32'h0000_4000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h0});
    send_pair('{32'hFFFF_FFFF, 32'h0, 32'h0008_0000, 32'h0, 32'h0, 32'h0});
    send_random(8);
  endtask

  // Crossed, zero and wide clamp bounds and the range of the constant
  task automatic test_clamps();
    set_regs(32'h0001_0000, 48'h0, 48'h0);
    send_random(40);
    set_regs(32'h0000_0100, 48'h0000_0100_0000, 48'h0000_0001_0000);
    send_random(40);
    set_regs(32'hFFFF_FFFF, 48'h0, 48'hFFFF_FFFF_FFFF);
    send_random(40);
    set_regs(32'h0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_random(30);
  endtask

  task automatic test_random_settings();
    repeat (8) begin
      set_regs($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0004_0000),
               48'({$urandom, $urandom}) & 48'h0000_00FF_FFFF,
               $urandom_range(0, 2) == 0 ? 48'({$urandom, $urandom})
                                         : 48'hFFFF_FFFF_FFFF);
      send_random(130);
    end
  endtask

  // Long receiver hold while items keep coming, then a full pause
  task automatic test_backpressure();
    set_regs(32'h0001_0000, 48'h0000_0001_0000, 48'hFFFF_FFFF_FFFF);
    hold_req = 1'b1;
    send_random(300);
    drain();
    send_random(60);
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    send_random(150);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    errors = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    grav_k = gfv_pkg::GRAV_RESET;
    dsq_lo = gfv_pkg::MIN_DSQ_RESET;
    dsq_hi = gfv_pkg::MAX_DSQ_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_clamps();
    test_random_settings();
    test_backpressure();
    test_back_to_back();
    in_tvalid <= 1'b0;
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
